/* hdl/worley_cellular_noise_2d_assert.svh */
// Assertion macros for the cellular noise block checker.
`ifndef WORLEY_CELLULAR_NOISE_2D_ASSERT_SVH
`define WORLEY_CELLULAR_NOISE_2D_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define WCN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define WCN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/wcn_pkg.sv */
// Shared constants, types and control codes of the cellular noise block.
`default_nettype none

package wcn_pkg;

    localparam int TABLE_ENTRIES    = 512;
    localparam int TBL_AW           = $clog2(TABLE_ENTRIES);
    localparam int NEAREST_KEPT_DEF = 4;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic CFG_FUNCTION_ORDER = 1'b0;
    localparam logic CFG_COORD_SCALE    = 1'b1;

    localparam logic [1:0]  ORDER_RESET = 2'd0;
    localparam logic [23:0] SCALE_RESET = 24'd65536;

    // neighbour visiting order
    localparam logic [3:0] NB_CENTRE = 4'd0;
    localparam logic [3:0] NB_W      = 4'd1;
    localparam logic [3:0] NB_E      = 4'd2;
    localparam logic [3:0] NB_S      = 4'd3;
    localparam logic [3:0] NB_N      = 4'd4;
    localparam logic [3:0] NB_SW     = 4'd5;
    localparam logic [3:0] NB_SE     = 4'd6;
    localparam logic [3:0] NB_NW     = 4'd7;
    localparam logic [3:0] NB_NE     = 4'd8;
    localparam logic [3:0] NB_LAST   = NB_NE;

    // edge gap squares
    localparam logic [1:0] GAP_FX  = 2'd0;
    localparam logic [1:0] GAP_FXC = 2'd1;
    localparam logic [1:0] GAP_FY  = 2'd2;
    localparam logic [1:0] GAP_FYC = 2'd3;

    localparam int          ROOT_W     = 18;
    localparam logic [4:0]  ROOT_LAST  = 5'(ROOT_W - 1);
    localparam logic [17:0] NOISE_MAX  = 18'h3FFFF;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SCALE, ST_SPLIT, ST_EDGESQ, ST_CHECK, ST_RD1, ST_RD2, ST_SEED,
        ST_LCGX, ST_LCGY, ST_OFFS, ST_DIST, ST_SQD, ST_KEEP, ST_ROOT0, ST_ROOT,
        ST_FINAL, ST_DONE
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CAPTURE, OP_SCALE, OP_SPLIT, OP_EDGESQ, OP_RD1, OP_RD2,
        OP_SEED, OP_LCGX, OP_LCGY, OP_OFFS, OP_DIST, OP_SQD, OP_KEEP, OP_ROOT0,
        OP_ROOT, OP_FINAL, OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [3:0] nb;
        logic [1:0] sq_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic       edge_ok;
        logic [3:0] npts;
        logic       out_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

/* hdl/wcn_ctrl.sv */
// Sequencer for the cellular noise block: walks cells, points and root steps.
`default_nettype none

module wcn_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              command,
    input  wire wcn_pkg::dp_stat_t stat,
    output wcn_pkg::dp_cmd_t       cmd
);
    import wcn_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic [3:0]  nb_reg, nb_next;
    logic [3:0]  pt_reg, pt_next;
    logic [1:0]  sqsel_reg, sqsel_next;
    logic [4:0]  it_reg, it_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            nb_reg    <= NB_CENTRE;
            pt_reg    <= '0;
            sqsel_reg <= GAP_FX;
            it_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            nb_reg    <= nb_next;
            pt_reg    <= pt_next;
            sqsel_reg <= sqsel_next;
            it_reg    <= it_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        nb_next    = nb_reg;
        pt_next    = pt_reg;
        sqsel_next = sqsel_reg;
        it_next    = it_reg;
        in_ready   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.nb     = nb_reg;
        cmd.sq_sel = sqsel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (command == CMD_EVAL)
                    begin
                        cmd.op     = OP_CAPTURE;
                        state_next = ST_SCALE;
                    end
                    else
                    begin
                        cmd.op = OP_LOAD;
                    end
                end
            end
            ST_SCALE:
            begin
                cmd.op     = OP_SCALE;
                state_next = ST_SPLIT;
            end
            ST_SPLIT:
            begin
                cmd.op     = OP_SPLIT;
                sqsel_next = GAP_FX;
                state_next = ST_EDGESQ;
            end
            ST_EDGESQ:
            begin
                cmd.op = OP_EDGESQ;
                if (sqsel_reg == GAP_FYC)
                begin
                    nb_next    = NB_CENTRE;
                    state_next = ST_CHECK;
                end
                else
                begin
                    sqsel_next = sqsel_reg + 2'd1;
                end
            end
            ST_CHECK:
            begin
                if (stat.edge_ok)
                begin
                    state_next = ST_RD1;
                end
                else if (nb_reg == NB_LAST)
                begin
                    state_next = ST_ROOT0;
                end
                else
                begin
                    nb_next = nb_reg + 4'd1;
                end
            end
            ST_RD1:
            begin
                cmd.op     = OP_RD1;
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                cmd.op     = OP_RD2;
                state_next = ST_SEED;
            end
            ST_SEED:
            begin
                cmd.op     = OP_SEED;
                pt_next    = '0;
                state_next = ST_LCGX;
            end
            ST_LCGX:
            begin
                cmd.op     = OP_LCGX;
                state_next = ST_LCGY;
            end
            ST_LCGY:
            begin
                cmd.op     = OP_LCGY;
                state_next = ST_OFFS;
            end
            ST_OFFS:
            begin
                cmd.op     = OP_OFFS;
                state_next = ST_DIST;
            end
            ST_DIST:
            begin
                cmd.op     = OP_DIST;
                state_next = ST_SQD;
            end
            ST_SQD:
            begin
                cmd.op     = OP_SQD;
                state_next = ST_KEEP;
            end
            ST_KEEP:
            begin
                cmd.op = OP_KEEP;
                if (pt_reg != stat.npts - 4'd1)
                begin
                    pt_next    = pt_reg + 4'd1;
                    state_next = ST_LCGX;
                end
                else if (nb_reg == NB_LAST)
                begin
                    state_next = ST_ROOT0;
                end
                else
                begin
                    nb_next    = nb_reg + 4'd1;
                    state_next = ST_CHECK;
                end
            end
            ST_ROOT0:
            begin
                cmd.op     = OP_ROOT0;
                it_next    = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.op = OP_ROOT;
                if (it_reg == ROOT_LAST)
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    it_next = it_reg + 5'd1;
                end
            end
            ST_FINAL:
            begin
                cmd.op     = OP_FINAL;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/wcn_datapath.sv */
// Datapath: table memory, scaling, generator, distance list, root and output stage.
`default_nettype none

module wcn_datapath #(
    parameter int NEAREST_KEPT = wcn_pkg::NEAREST_KEPT_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire wcn_pkg::dp_cmd_t           cmd,
    output wcn_pkg::dp_stat_t               stat,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [23:0]                cfg_data,
    input  wire logic signed [31:0]         x_coord,
    input  wire logic signed [31:0]         y_coord,
    input  wire logic [wcn_pkg::TBL_AW-1:0] table_index,
    input  wire logic [7:0]                 table_value,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [17:0]                     noise_value
);
    import wcn_pkg::*;

    localparam int CW = $clog2(NEAREST_KEPT + 1);
    localparam logic [30:0] LCG_MOD  = 31'h7FFF_FFFF;
    localparam logic [14:0] LCG_MUL  = 15'd16807;
    localparam logic [26:0] DIV1     = 27'd1023;
    localparam logic [26:0] DIV2     = 27'd2046;
    localparam logic [26:0] DIV3     = 27'd3069;
    localparam logic [16:0] ONE_Q16  = 17'h10000;
    localparam logic [15:0] COEF_F1  = 16'd46341;
    localparam logic [15:0] COEF_FN  = 16'd23170;
    localparam logic [34:0] ROUND_H  = 35'd32768;

    function automatic logic [30:0] lcg_next(input logic [30:0] s);
        logic [45:0] p;
        logic [31:0] t;
        logic [31:0] u;
        p = {15'd0, s} * {31'd0, LCG_MUL};
        t = {1'b0, p[30:0]} + {17'd0, p[45:31]};
        u = t - {1'b0, LCG_MOD};
        lcg_next = (t >= {1'b0, LCG_MOD}) ? u[30:0] : t[30:0];
    endfunction

    // round(r * 2^16 / 1023): shift estimate, then up to three corrections
    function automatic logic [16:0] offs_q16(input logic [9:0] r);
        logic [25:0] n;
        logic [16:0] q0;
        logic [26:0] prod;
        logic [26:0] rem;
        logic [1:0]  c;
        n    = {r, 16'd0} + 26'd511;
        q0   = {1'b0, n[25:10]} + {11'd0, n[25:20]};
        prod = {q0, 10'd0} - {10'd0, q0};
        rem  = {1'b0, n} - prod;
        c    = 2'(rem >= DIV1) + 2'(rem >= DIV2) + 2'(rem >= DIV3);
        offs_q16 = q0 + {15'd0, c};
    endfunction

    function automatic logic signed [1:0] nb_dx(input logic [3:0] nb);
        case (nb)
            NB_W, NB_SW, NB_NW: nb_dx = -2'sd1;
            NB_E, NB_SE, NB_NE: nb_dx = 2'sd1;
            default:            nb_dx = 2'sd0;
        endcase
    endfunction

    function automatic logic signed [1:0] nb_dy(input logic [3:0] nb);
        case (nb)
            NB_S, NB_SW, NB_SE: nb_dy = -2'sd1;
            NB_N, NB_NW, NB_NE: nb_dy = 2'sd1;
            default:            nb_dy = 2'sd0;
        endcase
    endfunction

    // config
    logic [1:0]  order_reg;
    logic [23:0] scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_RESET;
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_FUNCTION_ORDER)
                order_reg <= cfg_data[1:0];
            else
                scale_reg <= cfg_data;
        end
    end

    // permutation table
    logic [7:0]        mem [TABLE_ENTRIES];
    logic [7:0]        rd_data_reg;
    logic [TBL_AW-1:0] rd_addr;
    logic              rd_en;

    // payload
    logic signed [31:0] x_reg, y_reg;
    logic signed [56:0] xp_reg, yp_reg;
    logic [7:0]         cx_reg, cy_reg;
    logic [15:0]        fx_reg, fy_reg;
    logic [32:0]        gsq_reg [4];
    logic [30:0]        s_reg;
    logic [3:0]         npts_reg;
    logic [9:0]         rx_reg, ry_reg;
    logic [16:0]        offx_reg, offy_reg;
    logic signed [18:0] dx_reg, dy_reg;
    logic [34:0]        dx2_reg, dy2_reg;
    logic [35:0]        kept_reg [NEAREST_KEPT];
    logic [CW-1:0]      count_reg;
    logic [35:0]        rad_reg;
    logic [19:0]        rem_reg;
    logic [17:0]        root_reg;
    logic               inf_reg;
    logic [33:0]        mult_reg;
    logic [17:0]        noise_reg;
    logic               out_valid_reg;

    logic signed [1:0]  ox, oy;
    logic [7:0]         ii, jj;
    logic [16:0]        gap;
    logic [33:0]        gap_sq;
    logic [30:0]        s_new;
    logic [7:0]         seed;
    logic signed [18:0] dx, dy;
    logic signed [37:0] dx2, dy2;
    logic [35:0]        kth, v;
    logic               kth_inf;
    logic [32:0]        sqx, sqy;
    logic               pass_x, pass_y;
    logic               dup, drop;
    logic [CW-1:0]      pos;
    logic [35:0]        kept_new [NEAREST_KEPT];
    logic [19:0]        rem_sh, trial;
    logic [34:0]        rnd;
    logic [18:0]        res;

    assign ox = nb_dx(cmd.nb);
    assign oy = nb_dy(cmd.nb);
    assign ii = cx_reg + {{6{ox[1]}}, ox};
    assign jj = cy_reg + {{6{oy[1]}}, oy};

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = {1'b0, jj};
        if (cmd.op == OP_RD1)
        begin
            rd_en = 1'b1;
        end
        else if (cmd.op == OP_RD2)
        begin
            rd_en   = 1'b1;
            rd_addr = {1'b0, ii} + {1'b0, rd_data_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
            mem[table_index] <= table_value;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // edge gap squarer, one gap per cycle
    always_comb
    begin
        unique case (cmd.sq_sel)
            GAP_FX:  gap = {1'b0, fx_reg};
            GAP_FXC: gap = ONE_Q16 - {1'b0, fx_reg};
            GAP_FY:  gap = {1'b0, fy_reg};
            GAP_FYC: gap = ONE_Q16 - {1'b0, fy_reg};
            default: gap = '0;
        endcase
    end
    assign gap_sq = gap * gap;

    assign s_new = lcg_next(s_reg);
    assign seed  = rd_data_reg;

    assign dx  = $signed({2'b00, offx_reg}) - $signed({3'b000, fx_reg})
               + $signed({ox[1], ox, 16'd0});
    assign dy  = $signed({2'b00, offy_reg}) - $signed({3'b000, fy_reg})
               + $signed({oy[1], oy, 16'd0});
    assign dx2 = dx_reg * dx_reg;
    assign dy2 = dy_reg * dy_reg;

    // k-th kept distance
    always_comb
    begin
        kth = '0;
        for (int i = 0; i < NEAREST_KEPT; i++)
            if (i == int'(order_reg))
                kth = kept_reg[i];
    end
    assign kth_inf = int'(order_reg) >= int'(count_reg);

    assign sqx    = (ox < 0) ? gsq_reg[GAP_FX] : gsq_reg[GAP_FXC];
    assign sqy    = (oy < 0) ? gsq_reg[GAP_FY] : gsq_reg[GAP_FYC];
    assign pass_x = (ox == 2'sd0) || kth_inf || ({3'd0, sqx} < kth);
    assign pass_y = (oy == 2'sd0) || kth_inf || ({3'd0, sqy} < kth);

    // sorted insert of distinct distances
    assign v = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    always_comb
    begin
        dup = 1'b0;
        pos = '0;
        for (int i = 0; i < NEAREST_KEPT; i++)
        begin
            if (i < int'(count_reg))
            begin
                if (kept_reg[i] == v)
                    dup = 1'b1;
                if (kept_reg[i] < v)
                    pos = pos + CW'(1);
            end
        end
        drop = dup || ((int'(count_reg) == NEAREST_KEPT) && (v >= kept_reg[NEAREST_KEPT-1]));
        for (int i = 0; i < NEAREST_KEPT; i++)
        begin
            if (i < int'(pos))
                kept_new[i] = kept_reg[i];
            else if (i == int'(pos))
                kept_new[i] = v;
            else
                kept_new[i] = kept_reg[(i == 0) ? 0 : i - 1];
        end
    end

    assign rem_sh = {rem_reg[17:0], rad_reg[35:34]};
    assign trial  = {root_reg, 2'b01};

    assign rnd = {1'b0, mult_reg} + ROUND_H;
    assign res = rnd[34:16];

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_CAPTURE:
            begin
                x_reg <= x_coord;
                y_reg <= y_coord;
            end
            OP_SCALE:
            begin
                xp_reg <= x_reg * $signed({1'b0, scale_reg});
                yp_reg <= y_reg * $signed({1'b0, scale_reg});
            end
            OP_SPLIT:
            begin
                cx_reg <= xp_reg[39:32];
                fx_reg <= xp_reg[31:16];
                cy_reg <= yp_reg[39:32];
                fy_reg <= yp_reg[31:16];
            end
            OP_EDGESQ:
            begin
                gsq_reg[cmd.sq_sel] <= gap_sq[32:0];
            end
            OP_SEED:
            begin
                s_reg    <= (seed == 8'd0) ? 31'd1 : {23'd0, seed};
                npts_reg <= {1'b0, seed[2:0]} + 4'd1;
            end
            OP_LCGX:
            begin
                s_reg  <= s_new;
                rx_reg <= s_new[9:0];
            end
            OP_LCGY:
            begin
                s_reg  <= s_new;
                ry_reg <= s_new[9:0];
            end
            OP_OFFS:
            begin
                offx_reg <= offs_q16(rx_reg);
                offy_reg <= offs_q16(ry_reg);
            end
            OP_DIST:
            begin
                dx_reg <= dx;
                dy_reg <= dy;
            end
            OP_SQD:
            begin
                dx2_reg <= dx2[34:0];
                dy2_reg <= dy2[34:0];
            end
            OP_KEEP:
            begin
                if (!drop)
                    kept_reg <= kept_new;
            end
            OP_ROOT0:
            begin
                rad_reg  <= kth;
                inf_reg  <= kth_inf;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            OP_ROOT:
            begin
                rad_reg <= {rad_reg[33:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[16:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[16:0], 1'b0};
                end
            end
            OP_FINAL:
            begin
                mult_reg <= root_reg * ((order_reg == 2'd0) ? COEF_F1 : COEF_FN);
            end
            OP_OUT:
            begin
                if (inf_reg || (res > {1'b0, NOISE_MAX}))
                    noise_reg <= NOISE_MAX;
                else
                    noise_reg <= res[17:0];
            end
            default:
            begin
            end
        endcase
    end

    // kept count and output flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_SPLIT)
                count_reg <= '0;
            else if ((cmd.op == OP_KEEP) && !drop && (int'(count_reg) < NEAREST_KEPT))
                count_reg <= count_reg + CW'(1);
            if (cmd.op == OP_OUT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign stat.edge_ok  = pass_x && pass_y;
    assign stat.npts     = npts_reg;
    assign stat.out_busy = out_valid_reg && !out_ready;

    assign out_valid   = out_valid_reg;
    assign noise_value = noise_reg;

endmodule

`default_nettype wire

/* hdl/worley_cellular_noise_2d.sv */
// Two-dimensional cellular noise over a loadable permutation table.
//
// Input channel (in_valid/in_ready): a beat with command = load writes
// table_value into entry table_index and gives no result; a beat with
// command = evaluate samples the noise at (x_coord, y_coord), signed Q16.16.
// A load beat is taken back to back with later beats.
// The run time of an evaluate beat depends on C, the number of cells
// visited (1 to 9), and P, the feature points found in them (1 to 72).
// The point loop (two generator steps, offset, distance, square, insert)
// and an 18-step square root set it.
// in_ready is high only while the sequencer is idle.
// Output channel (out_valid/out_ready): one beat of noise_value, unsigned
// Q2.16, per evaluate. The result waits in an output register, so the next
// beat is accepted while it is still held; a new evaluate only stalls at its
// last cycle if the receiver has not yet taken the previous beat.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 function_order,
// index 1 coord_scale (Q8.16); write only while idle.
// Reset: function_order 0, coord_scale 1.0, no result pending. The table is
// not cleared; load every entry an evaluate may read before using it.
`default_nettype none

module worley_cellular_noise_2d #(
    parameter int NEAREST_KEPT = wcn_pkg::NEAREST_KEPT_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       command,
    input  wire logic signed [31:0]         x_coord,
    input  wire logic signed [31:0]         y_coord,
    input  wire logic [wcn_pkg::TBL_AW-1:0] table_index,
    input  wire logic [7:0]                 table_value,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [17:0]                     noise_value,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic                       cfg_index,
    input  wire logic [23:0]                cfg_data
);
    import wcn_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // registers are plain flops, a write is always taken
    assign cfg_ready = 1'b1;

    wcn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .stat     (stat),
        .cmd      (cmd)
    );

    wcn_datapath #(
        .NEAREST_KEPT (NEAREST_KEPT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .table_index (table_index),
        .table_value (table_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .noise_value (noise_value)
    );

endmodule

`default_nettype wire

/* hdl/wcn_checker.sv */
// Port-level checker for the cellular noise block, bound to the top level.
`default_nettype none
`include "worley_cellular_noise_2d_assert.svh"

module wcn_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        command,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [17:0] noise_value
);
    import wcn_pkg::*;

    // a held result beat keeps its value
    `WCN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(noise_value), "result beat changed while stalled")

    // a table load never produces a result
    `WCN_ASSERT_NEXT(a_load_silent, in_valid && in_ready && (command == CMD_LOAD), !$rose(out_valid), "load beat produced a result")

    // the input side only closes behind an evaluate beat
    `WCN_ASSERT_NOW(a_busy_cause, $fell(in_ready), $past(in_valid) && $past(command == CMD_EVAL), "input closed without an evaluate")

endmodule

bind worley_cellular_noise_2d wcn_checker u_wcn_checker (.*);

`default_nettype wire
